@@ hdl/kvt_pkg.sv @@
// Shared types and constants for the key/value table.
package kvt_pkg;

   localparam int OPCODE_WIDTH = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int FIELD_WIDTH  = 32;
   localparam int REQ_BITS     = OPCODE_WIDTH + 2 * FIELD_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS     = STATUS_WIDTH + FIELD_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_SET    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

endpackage

@@ hdl/kvt_ram.sv @@
// Simple dual-port slot memory with a registered read.
module kvt_ram
   import kvt_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/key_value_table.sv @@
// A bounded table of unique key/value pairs with set, get and remove requests. Keys and
// values sit in one slot memory with a single read port; valid marks are flip-flops cleared
// by reset. Each request scans the slots one read a cycle, stopping at a key match, and
// then takes a write step that updates the table and the result, so the block works on
// one request at a time. A set of a new key goes to the lowest free slot; a full table
// reports status 2.
module key_value_table
   import kvt_pkg::*;
#(
   parameter int ENTRIES     = 16,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // opcode [1:0], lookup_key [33:2], write_value [65:34], zero pad above
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status [1:0], read_value [33:2], zero pad above
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int MEM_W = KEY_WIDTH + VALUE_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE
   } state_type;

   state_type              state_ff, state_in;
   logic [ENTRIES-1:0]     slot_valid_ff, slot_valid_in;
   opcode_type             op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]       issue_cnt_ff, issue_cnt_in;
   logic                   pend_ff, pend_in;
   logic                   pend_live_ff, pend_live_in;
   logic                   pend_last_ff, pend_last_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [VALUE_WIDTH-1:0] hit_val_ff, hit_val_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [FIELD_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [MEM_W-1:0]       ram_wr_data;
   logic                   ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [MEM_W-1:0]       ram_rd_data;
   logic [KEY_WIDTH-1:0]   rd_key;
   logic [VALUE_WIDTH-1:0] rd_val;

   assign rd_key      = ram_rd_data[KEY_WIDTH-1:0];
   assign rd_val      = ram_rd_data[MEM_W-1:KEY_WIDTH];
   assign ram_rd_addr = issue_cnt_ff[IDX_W-1:0];

   // Reads happen only in the scan and writes only after it, so no access overlaps.
   kvt_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (MEM_W)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      issue_cnt_in  = issue_cnt_ff;
      pend_in       = pend_ff;
      pend_live_in  = pend_live_ff;
      pend_last_in  = pend_last_ff;
      pend_idx_in   = pend_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = {val_ff, key_ff};
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = opcode_type'(req_tdata[OPCODE_WIDTH-1:0]);
               key_in        = KEY_WIDTH'(req_tdata[OPCODE_WIDTH +: FIELD_WIDTH]);
               val_in        = VALUE_WIDTH'(req_tdata[OPCODE_WIDTH+FIELD_WIDTH +: FIELD_WIDTH]);
               issue_cnt_in  = '0;
               pend_in       = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            // Issue one slot read per cycle; note the first free slot on the way.
            if (issue_cnt_ff < CNT_W'(ENTRIES)) begin
               ram_rd_en    = 1'b1;
               pend_in      = 1'b1;
               pend_idx_in  = issue_cnt_ff[IDX_W-1:0];
               pend_live_in = slot_valid_ff[issue_cnt_ff[IDX_W-1:0]];
               pend_last_in = (issue_cnt_ff == CNT_W'(ENTRIES - 1));
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               if (!slot_valid_ff[issue_cnt_ff[IDX_W-1:0]] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = issue_cnt_ff[IDX_W-1:0];
               end
            end else begin
               pend_in = 1'b0;
            end
            // Compare the slot read in the previous cycle.
            if (pend_ff) begin
               if (pend_live_ff && (rd_key == key_ff)) begin
                  hit_in     = 1'b1;
                  hit_idx_in = pend_idx_ff;
                  hit_val_in = rd_val;
                  state_in   = S_WRITE;
               end else if (pend_last_ff) begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISSING;
               rsp_value_in  = '0;
               state_in      = S_IDLE;
               unique case (op_ff)
                  OP_SET: begin
                     if (hit_ff) begin
                        ram_wr_en     = 1'b1;
                        rsp_status_in = ST_OK;
                     end else if (free_found_ff) begin
                        ram_wr_en                  = 1'b1;
                        ram_wr_addr                = free_idx_ff;
                        slot_valid_in[free_idx_ff] = 1'b1;
                        rsp_status_in              = ST_OK;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  OP_GET: begin
                     if (hit_ff) begin
                        rsp_status_in = ST_OK;
                        rsp_value_in  = FIELD_WIDTH'(hit_val_ff);
                     end
                  end
                  OP_REMOVE: begin
                     if (hit_ff) begin
                        slot_valid_in[hit_idx_ff] = 1'b0;
                        rsp_status_in             = ST_OK;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_MISSING;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         pend_ff       <= pend_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      issue_cnt_ff  <= issue_cnt_in;
      pend_live_ff  <= pend_live_in;
      pend_last_ff  <= pend_last_in;
      pend_idx_ff   <= pend_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_val_ff    <= hit_val_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'({rsp_value_ff, rsp_status_ff});

`ifndef SYNTHESIS
   // One request in flight: an accepted request drops ready, so the next one is blocked.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A hit always points at a live slot.
   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && hit_ff) |-> slot_valid_ff[hit_idx_ff])
      else $error("hit on a slot that is not valid");

   // A pending result that is not taken keeps the write step waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_WRITE))
      else $error("result register overwritten");

   // An insert marks the chosen free slot valid.
   a_insert_marks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && (!rsp_valid_ff || rsp_tready) && op_ff == OP_SET
       && !hit_ff && free_found_ff) |=> slot_valid_ff[$past(free_idx_ff)])
      else $error("insert did not mark its slot valid");
`endif

endmodule
